@@ rtl/core/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// shared types and constants of the sprite pair collision unit
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int POS_DEPTH = 8;
    localparam int ROW_DEPTH = 32;
    localparam int PAIRS     = 6;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam logic [5:0] POS_PAGE  = 6'h1E;
    localparam logic [3:0] ROW_PAGE  = 4'hC;
    localparam logic [8:0] COLL_ADDR = 9'h1FD;
    localparam logic [7:0] PAIR_MASK = 8'h3F;

    typedef struct packed {
        logic       pos_we;
        logic [2:0] pos_waddr;
        logic [2:0] pos_raddr;
        logic       row_we;
        logic [4:0] row_waddr;
        logic [4:0] row_raddr;
        logic [7:0] wdata;
    } spc_mem_req_t;

    function automatic logic [1:0] pair_first(input logic [2:0] p);
        logic [1:0] s;
        unique case (p)
            3'd0, 3'd1, 3'd2: s = 2'd0;
            3'd3, 3'd4:       s = 2'd1;
            3'd5:             s = 2'd2;
            default:          s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] pair_second(input logic [2:0] p);
        logic [1:0] s;
        unique case (p)
            3'd0:             s = 2'd1;
            3'd1, 3'd3:       s = 2'd2;
            3'd2, 3'd4, 3'd5: s = 2'd3;
            default:          s = 2'd1;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/spc_ram.sv @@
// ----------------------------------------------------------------------------
// spc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/spc_store.sv @@
// ----------------------------------------------------------------------------
// spc_store
// position and image row memories with per-entry valid bits; entries never
// written since reset read back as zero
// ----------------------------------------------------------------------------
module spc_store
    import spc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  spc_mem_req_t req,
    output logic [7:0]   pos_q,
    output logic [7:0]   row_q
);

    logic [POS_DEPTH-1:0] pos_vld_reg;
    logic [ROW_DEPTH-1:0] row_vld_reg;
    logic                 pos_rvld_reg;
    logic                 row_rvld_reg;
    logic [7:0]           pos_rdata;
    logic [7:0]           row_rdata;

    spc_ram #(.WIDTH(8), .DEPTH(POS_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (req.pos_we),
        .waddr (req.pos_waddr),
        .wdata (req.wdata),
        .raddr (req.pos_raddr),
        .rdata (pos_rdata)
    );

    spc_ram #(.WIDTH(8), .DEPTH(ROW_DEPTH)) u_row_ram (
        .clk   (clk),
        .we    (req.row_we),
        .waddr (req.row_waddr),
        .wdata (req.wdata),
        .raddr (req.row_raddr),
        .rdata (row_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_vld_reg  <= '0;
            row_vld_reg  <= '0;
            pos_rvld_reg <= 1'b0;
            row_rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.pos_we)
            begin
                pos_vld_reg[req.pos_waddr] <= 1'b1;
            end
            if (req.row_we)
            begin
                row_vld_reg[req.row_waddr] <= 1'b1;
            end
            pos_rvld_reg <= pos_vld_reg[req.pos_raddr];
            row_rvld_reg <= row_vld_reg[req.row_raddr];
        end
    end

    assign pos_q = pos_rvld_reg ? pos_rdata : 8'h00;
    assign row_q = row_rvld_reg ? row_rdata : 8'h00;

endmodule

@@ rtl/core/sprite_pair_collision_unit.sv @@
// ----------------------------------------------------------------------------
// sprite_pair_collision_unit
// sprite position and image registers with a frame-end pair collision check
// ----------------------------------------------------------------------------
// write, no-op, collision byte or unmapped read: the result goes through S_OUT
//   to the registered output; a new request is taken only back in S_IDLE
// position or image read: S_RDATA takes the registered memory read data, then S_OUT
// frame end: each pair runs S_PAIR, S_PXA, S_PYB, S_PXB and S_DX (position reads),
//   then up to 8 row steps of S_RA, S_RB and S_CMP on the single row read port
// reset clears the collision byte and marks all stored bytes as zero
// ----------------------------------------------------------------------------
module sprite_pair_collision_unit
    import spc_pkg::*;
#(
    parameter int NUM_SPRITES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [8:0] address,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RDATA = 11'b000_0000_0010,
        S_OUT   = 11'b000_0000_0100,
        S_PAIR  = 11'b000_0000_1000,
        S_PXA   = 11'b000_0001_0000,
        S_PYB   = 11'b000_0010_0000,
        S_PXB   = 11'b000_0100_0000,
        S_DX    = 11'b000_1000_0000,
        S_RA    = 11'b001_0000_0000,
        S_RB    = 11'b010_0000_0000,
        S_CMP   = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         pair_reg, pair_next;
    logic [2:0]         k_reg, k_next;
    logic [7:0]         pa_reg, pa_next;
    logic [7:0]         xa_reg, xa_next;
    logic [7:0]         pb_reg, pb_next;
    logic signed [3:0]  dx_reg, dx_next;
    logic signed [8:0]  d_reg, d_next;
    logic [7:0]         ra_reg, ra_next;
    logic [7:0]         res_reg, res_next;
    logic [7:0]         coll_reg, coll_next;
    logic               sel_row_reg, sel_row_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         data_reg, data_next;

    spc_mem_req_t       mem_req;
    logic [7:0]         pos_q;
    logic [7:0]         row_q;

    logic               accept;
    logic               is_pos;
    logic               is_row;
    logic               is_coll;
    logic [1:0]         sa;
    logic [1:0]         sb;
    logic               pair_live;
    logic               last_pair;
    logic signed [8:0]  diff;
    logic signed [9:0]  j;
    logic               j_in;
    logic [3:0]         neg_dx;
    logic [7:0]         ra_sh;
    logic [7:0]         rb_sh;
    logic               go_k;
    logic               go_pair;

    spc_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .pos_q (pos_q),
        .row_q (row_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_pos   = (address[8:3] == POS_PAGE);
    assign is_row   = (address[8:5] == ROW_PAGE);
    assign is_coll  = (address == COLL_ADDR);

    assign sa        = pair_first(pair_reg);
    assign sb        = pair_second(pair_reg);
    assign pair_live = ({1'b0, sb} < 3'(NUM_SPRITES));
    assign last_pair = (pair_reg == 3'(PAIRS - 1));

    assign diff   = $signed({1'b0, xa_reg}) - $signed({1'b0, pos_q});
    assign j      = $signed({d_reg[8], d_reg}) + $signed({7'b0, k_reg});
    assign j_in   = (j[9:3] == 7'd0);
    assign neg_dx = 4'(-dx_reg);
    assign ra_sh  = dx_reg[3] ? ra_reg : (ra_reg >> dx_reg[2:0]);
    assign rb_sh  = dx_reg[3] ? (row_q >> neg_dx[2:0]) : row_q;

    always_comb
    begin
        state_next   = state_reg;
        pair_next    = pair_reg;
        k_next       = k_reg;
        pa_next      = pa_reg;
        xa_next      = xa_reg;
        pb_next      = pb_reg;
        dx_next      = dx_reg;
        d_next       = d_reg;
        ra_next      = ra_reg;
        res_next     = res_reg;
        coll_next    = coll_reg;
        sel_row_next = sel_row_reg;
        go_k         = 1'b0;
        go_pair      = 1'b0;

        mem_req           = '0;
        mem_req.pos_waddr = address[2:0];
        mem_req.row_waddr = address[4:0];
        mem_req.wdata     = write_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = 8'h00;
                    state_next = S_OUT;
                    case (kind)
                        KIND_WRITE:
                        begin
                            mem_req.pos_we = is_pos;
                            mem_req.row_we = is_row;
                            if (is_coll)
                            begin
                                coll_next = write_data;
                            end
                        end
                        KIND_READ:
                        begin
                            mem_req.pos_raddr = address[2:0];
                            mem_req.row_raddr = address[4:0];
                            sel_row_next      = is_row;
                            if (is_pos || is_row)
                            begin
                                state_next = S_RDATA;
                            end
                            else if (is_coll)
                            begin
                                res_next = coll_reg;
                            end
                        end
                        KIND_FRAME:
                        begin
                            coll_next  = coll_reg | PAIR_MASK;
                            pair_next  = 3'd0;
                            state_next = S_PAIR;
                        end
                        default:
                        begin
                            res_next = 8'h00;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                res_next   = sel_row_reg ? row_q : pos_q;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAIR:
            begin
                if (pair_live)
                begin
                    mem_req.pos_raddr = {sa, 1'b0};
                    state_next        = S_PXA;
                end
                else
                begin
                    go_pair = 1'b1;
                end
            end
            S_PXA:
            begin
                pa_next           = pos_q;
                mem_req.pos_raddr = {sa, 1'b1};
                state_next        = S_PYB;
            end
            S_PYB:
            begin
                xa_next           = pos_q;
                mem_req.pos_raddr = {sb, 1'b0};
                state_next        = S_PXB;
            end
            S_PXB:
            begin
                pb_next           = pos_q;
                mem_req.pos_raddr = {sb, 1'b1};
                state_next        = S_DX;
            end
            S_DX:
            begin
                dx_next = diff[3:0];
                d_next  = $signed({1'b0, pb_reg}) - $signed({1'b0, pa_reg});
                k_next  = 3'd0;
                if ((diff > -9'sd8) && (diff < 9'sd8))
                begin
                    state_next = S_RA;
                end
                else
                begin
                    go_pair = 1'b1;
                end
            end
            S_RA:
            begin
                if (j_in)
                begin
                    mem_req.row_raddr = {sa, k_reg};
                    state_next        = S_RB;
                end
                else
                begin
                    go_k = 1'b1;
                end
            end
            S_RB:
            begin
                ra_next           = row_q;
                mem_req.row_raddr = {sb, j[2:0]};
                state_next        = S_CMP;
            end
            S_CMP:
            begin
                if ((ra_sh & rb_sh) != 8'h00)
                begin
                    coll_next = coll_reg & ~(8'd1 << pair_reg);
                    go_pair   = 1'b1;
                end
                else
                begin
                    go_k = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_k)
        begin
            if (k_reg == 3'd7)
            begin
                go_pair = 1'b1;
            end
            else
            begin
                k_next     = k_reg + 3'd1;
                state_next = S_RA;
            end
        end

        if (go_pair)
        begin
            if (last_pair)
            begin
                res_next   = 8'h00;
                state_next = S_OUT;
            end
            else
            begin
                pair_next  = pair_reg + 3'd1;
                state_next = S_PAIR;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        data_next      = data_reg;
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            data_next      = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coll_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
            pair_reg      <= 3'd0;
            k_reg         <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            coll_reg      <= coll_next;
            out_valid_reg <= out_valid_next;
            pair_reg      <= pair_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg      <= pa_next;
        xa_reg      <= xa_next;
        pb_reg      <= pb_next;
        dx_reg      <= dx_next;
        d_reg       <= d_next;
        ra_reg      <= ra_next;
        res_reg     <= res_next;
        sel_row_reg <= sel_row_next;
        data_reg    <= data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = data_reg;

endmodule
